// ===== rtl/core/dbi_pkg.sv =====
// ----------------------------------------------------------------------------
// dbi_pkg
// Shared types and constants for the depth bucket insert block.
// ----------------------------------------------------------------------------
package dbi_pkg;

    localparam int BUCKETS  = 4096;
    localparam int CAPACITY = 1024;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int CAP_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 24;
    localparam int RNG_W  = 23;
    localparam int DIFF_W = POS_W + 1;
    localparam int SUM_W  = 2 * DIFF_W;
    localparam int ROOT_W = DIFF_W;
    localparam int PROD_W = ROOT_W + BKT_W;
    localparam int LIM_W  = RNG_W + BKT_W + 1;
    localparam int CMP_W  = (LIM_W > PROD_W) ? LIM_W : PROD_W;
    localparam int STAT_W = 2;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [RNG_W-1:0] RANGE_RESET = RNG_W'(12800);

    localparam logic [1:0] REG_EYE_X       = 2'd0;
    localparam logic [1:0] REG_EYE_Y       = 2'd1;
    localparam logic [1:0] REG_EYE_Z       = 2'd2;
    localparam logic [1:0] REG_DEPTH_RANGE = 2'd3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 2'd2;

    typedef struct packed {
        logic                    func;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CAP_W-1:0]  slot;
        logic [BKT_W-1:0]  bucket;
        logic [CNT_W-1:0]  prev_head;
    } out_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] eye_x;
        logic signed [POS_W-1:0] eye_y;
        logic signed [POS_W-1:0] eye_z;
        logic [RNG_W-1:0]        depth_range;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       sweep_init;
        logic       sweep_wr;
        logic       diff;
        logic       sq;
        logic       acc;
        logic [1:0] axis;
        logic       root_go;
        logic       scale;
        logic       clamp;
        logic       div_go;
        logic       div_take;
        logic       rd;
        logic       wr;
        logic       reply_ins;
        logic       reply_full;
        logic       reply_clr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic sweep_last;
        logic root_done;
        logic div_done;
        logic over;
    } stat_t;

endpackage

// ===== rtl/core/dbi_sqrt.sv =====
// ----------------------------------------------------------------------------
// dbi_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dbi_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [dbi_pkg::SUM_W-1:0]  radicand,
    output logic [dbi_pkg::ROOT_W-1:0] root,
    output logic                       done
);
    import dbi_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CW    = $clog2(ROOT_W);

    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CW-1:0]     cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(ROOT_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/dbi_div.sv =====
// ----------------------------------------------------------------------------
// dbi_div
// Restoring divider for the bucket index, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbi_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [dbi_pkg::PROD_W-1:0] num,
    input  logic [dbi_pkg::RNG_W-1:0]  den,
    output logic [dbi_pkg::BKT_W-1:0]  quot,
    output logic                       done
);
    import dbi_pkg::*;

    localparam int CW = (BKT_W > 1) ? $clog2(BKT_W) : 1;

    logic [RNG_W-1:0] rem_reg;
    logic [RNG_W-1:0] den_reg;
    logic [BKT_W-1:0] lo_reg;
    logic [BKT_W-1:0] q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [RNG_W:0] rem_sh;
    logic [RNG_W:0] dsub;
    logic           fits;

    // numerator is below den << BKT_W, so the upper part starts below den
    assign rem_sh = {rem_reg, lo_reg[BKT_W-1]};
    assign dsub   = rem_sh - {1'b0, den_reg};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(BKT_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= num[BKT_W +: RNG_W];
            lo_reg  <= num[BKT_W-1:0];
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? dsub[RNG_W-1:0] : rem_sh[RNG_W-1:0];
            lo_reg  <= lo_reg << 1;
            q_reg   <= {q_reg[BKT_W-2:0], fits};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/dbi_dp.sv =====
// ----------------------------------------------------------------------------
// dbi_dp
// Datapath: distance, bucket scaling, head table memory and slot counter.
// ----------------------------------------------------------------------------
module dbi_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  dbi_pkg::cfg_t      cfg,
    input  dbi_pkg::in_item_t  item,
    input  dbi_pkg::cmd_t      cmd,
    output dbi_pkg::stat_t     stat,
    output logic               done,
    output dbi_pkg::out_item_t result
);
    import dbi_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [POS_W-1:0] a,
        input logic [POS_W-1:0] b
    );
        logic [DIFF_W-1:0] d;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        return d[DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    logic [CNT_W-1:0] heads_mem [BUCKETS];

    in_item_t          item_reg;
    logic [DIFF_W-1:0] ax_reg;
    logic [DIFF_W-1:0] ay_reg;
    logic [DIFF_W-1:0] az_reg;
    logic [SUM_W-1:0]  sq_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CMP_W-1:0]  lim_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [CNT_W-1:0]  rdata_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [BKT_W-1:0]  sweep_reg;
    logic              done_reg;
    out_item_t         result_reg;

    logic [DIFF_W-1:0] sq_sel;
    logic [RNG_W-1:0]  range_eff;
    logic [ROOT_W-1:0] root;
    logic              root_done;
    logic [BKT_W-1:0]  quot;
    logic              div_done;
    logic              mem_we;
    logic [BKT_W-1:0]  mem_addr;
    logic [CNT_W-1:0]  mem_wdata;

    dbi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.root_go),
        .radicand (acc_reg),
        .root     (root),
        .done     (root_done)
    );

    dbi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (prod_reg),
        .den   (range_eff),
        .quot  (quot),
        .done  (div_done)
    );

    assign range_eff = (cfg.depth_range == '0) ? RNG_W'(1) : cfg.depth_range;

    always_comb
    begin
        case (cmd.axis)
            2'd0:    sq_sel = ax_reg;
            2'd1:    sq_sel = ay_reg;
            2'd2:    sq_sel = az_reg;
            default: sq_sel = '0;
        endcase
    end

    assign mem_we    = cmd.sweep_wr || cmd.wr;
    assign mem_addr  = cmd.sweep_wr ? sweep_reg : bucket_reg;
    assign mem_wdata = cmd.sweep_wr ? CNT_W'(CAPACITY) : used_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heads_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= heads_mem[bucket_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
            acc_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + sq_reg;
        end
        if (cmd.diff)
        begin
            ax_reg <= abs_diff(item_reg.pos_x, cfg.eye_x);
            ay_reg <= abs_diff(item_reg.pos_y, cfg.eye_y);
            az_reg <= abs_diff(item_reg.pos_z, cfg.eye_z);
        end
        if (cmd.sq)
        begin
            sq_reg <= SUM_W'(sq_sel) * SUM_W'(sq_sel);
        end
        if (cmd.scale)
        begin
            prod_reg <= PROD_W'(root) * PROD_W'(BUCKETS - 1);
            lim_reg  <= CMP_W'(range_eff) * CMP_W'(BUCKETS);
        end
        if (cmd.clamp)
        begin
            bucket_reg <= BKT_W'(BUCKETS - 1);
        end
        else if (cmd.div_take)
        begin
            bucket_reg <= quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reply_ins || cmd.reply_full || cmd.reply_clr;
            if (cmd.sweep_init)
            begin
                used_reg  <= '0;
                sweep_reg <= '0;
            end
            else
            begin
                if (cmd.wr)
                begin
                    used_reg <= used_reg + 1'b1;
                end
                if (cmd.sweep_wr)
                begin
                    sweep_reg <= stat.sweep_last ? '0 : sweep_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reply_ins)
        begin
            result_reg.status    <= STAT_INSERTED;
            result_reg.slot      <= used_reg[CAP_W-1:0];
            result_reg.bucket    <= bucket_reg;
            result_reg.prev_head <= rdata_reg;
        end
        else if (cmd.reply_full || cmd.reply_clr)
        begin
            result_reg.status    <= cmd.reply_clr ? STAT_CLEARED : STAT_FULL;
            result_reg.slot      <= '0;
            result_reg.bucket    <= '0;
            result_reg.prev_head <= '0;
        end
    end

    assign stat.full       = (used_reg >= CNT_W'(CAPACITY));
    assign stat.sweep_last = (sweep_reg == BKT_W'(BUCKETS - 1));
    assign stat.root_done  = root_done;
    assign stat.div_done   = div_done;
    assign stat.over       = (CMP_W'(prod_reg) >= lim_reg);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/dbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbi_ctrl
// Controller state machine sequencing one request through the datapath.
// ----------------------------------------------------------------------------
module dbi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           func,
    input  dbi_pkg::stat_t stat,
    output dbi_pkg::cmd_t  cmd,
    output logic           busy
);
    import dbi_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SWEEP   = 4'd1;
    localparam logic [3:0] S_FULL    = 4'd2;
    localparam logic [3:0] S_DIFF    = 4'd3;
    localparam logic [3:0] S_SQ      = 4'd4;
    localparam logic [3:0] S_ROOT_GO = 4'd5;
    localparam logic [3:0] S_ROOT    = 4'd6;
    localparam logic [3:0] S_SCALE   = 4'd7;
    localparam logic [3:0] S_CLAMP   = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;
    localparam logic [3:0] S_READ    = 4'd10;
    localparam logic [3:0] S_WRITE   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic       clr_reply_reg;
    logic       clr_reply_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        clr_reply_next = clr_reply_reg;
        cmd            = '0;
        cmd.axis       = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (func == FUNC_CLEAR)
                    begin
                        cmd.sweep_init = 1'b1;
                        clr_reply_next = 1'b1;
                        state_next     = S_SWEEP;
                    end
                    else if (stat.full)
                    begin
                        state_next = S_FULL;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.reply_clr  = clr_reply_reg;
                    clr_reply_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_FULL:
            begin
                cmd.reply_full = 1'b1;
                state_next     = S_IDLE;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                axis_next  = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq    = (axis_reg != 2'd3);
                cmd.acc   = (axis_reg != 2'd0);
                axis_next = axis_reg + 1'b1;
                if (axis_reg == 2'd3)
                begin
                    state_next = S_ROOT_GO;
                end
            end
            S_ROOT_GO:
            begin
                cmd.root_go = 1'b1;
                state_next  = S_ROOT;
            end
            S_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (stat.over)
                begin
                    cmd.clamp  = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    cmd.div_go = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr        = 1'b1;
                cmd.reply_ins = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            axis_reg      <= 2'd0;
            clr_reply_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            clr_reply_reg <= clr_reply_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/depth_bucket_insert_top.sv =====
// ----------------------------------------------------------------------------
// depth_bucket_insert_top
// Bins items into depth buckets by distance from the eye point and pushes
// each onto the head of its bucket list.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  config    psel penable pwrite paddr ...    apb write, pready always high
//  request   start item busy                  taken when start and not busy
//  result    done result                      one-cycle strobe, no stall
//
//  an insert waits on the bit-serial square root and, unless the bucket is
//  clamped, on the bucket divider, then does the head table read and write
//  a full-store insert answers without computing a bucket
//  a clear request and reset sweep the head table, busy high
//  config writes are taken at any time, also during the sweep
// ----------------------------------------------------------------------------
module depth_bucket_insert_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbi_pkg::ADDR_W-1:0] paddr,
    input  logic [dbi_pkg::DATA_W-1:0] pwdata,
    output logic [dbi_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       start,
    input  dbi_pkg::in_item_t          item,
    output logic                       busy,
    output logic                       done,
    output dbi_pkg::out_item_t         result
);
    import dbi_pkg::*;

    logic [POS_W-1:0] eye_x_reg;
    logic [POS_W-1:0] eye_y_reg;
    logic [POS_W-1:0] eye_z_reg;
    logic [RNG_W-1:0] range_reg;

    logic       wr_en;
    logic [1:0] reg_idx;
    cfg_t       cfg;
    cmd_t       cmd;
    stat_t      stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg <= '0;
            eye_y_reg <= '0;
            eye_z_reg <= '0;
            range_reg <= RANGE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EYE_X:       eye_x_reg <= pwdata[POS_W-1:0];
                REG_EYE_Y:       eye_y_reg <= pwdata[POS_W-1:0];
                REG_EYE_Z:       eye_z_reg <= pwdata[POS_W-1:0];
                REG_DEPTH_RANGE: range_reg <= pwdata[RNG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_EYE_X:       prdata = DATA_W'(eye_x_reg);
            REG_EYE_Y:       prdata = DATA_W'(eye_y_reg);
            REG_EYE_Z:       prdata = DATA_W'(eye_z_reg);
            REG_DEPTH_RANGE: prdata = DATA_W'(range_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.eye_x       = eye_x_reg;
    assign cfg.eye_y       = eye_y_reg;
    assign cfg.eye_z       = eye_z_reg;
    assign cfg.depth_range = range_reg;

    dbi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (item.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dbi_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

// ===== rtl/core/dbi_checker.sv =====
// ----------------------------------------------------------------------------
// dbi_checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module dbi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input dbi_pkg::out_item_t result
);
    import dbi_pkg::*;

    // one result per request, the block is idle when it answers
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STAT_INSERTED || result.status == STAT_FULL ||
                  result.status == STAT_CLEARED))
        else $error("bad result status");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STAT_INSERTED |->
            result.slot == '0 && result.bucket == '0 && result.prev_head == '0)
        else $error("nonzero fields on full or clear result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == STAT_INSERTED |->
            result.prev_head <= CNT_W'(CAPACITY))
        else $error("previous head out of range");

endmodule

bind depth_bucket_insert_top dbi_checker u_dbi_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
